@@ src/lps_pkg.sv @@
// lps_pkg: shared types, constants and pattern tables for the led pattern sequencer
// no dependencies

package lps_pkg;

    localparam int PATTERN_COUNT = 4;

    localparam int OP_W    = 3;
    localparam int PAT_W   = 2;
    localparam int DELAY_W = 14;
    localparam int STEP_W  = 10;
    localparam int IDX_W   = 5;
    localparam int LED_W   = 8;
    localparam int ADDR_W  = 6;
    localparam int CFG_W   = 14;
    localparam int NUM_PAT = 4;

    localparam logic [PAT_W:0]     PAT_LIMIT   = (PAT_W + 1)'(PATTERN_COUNT);
    localparam logic [DELAY_W-1:0] RESET_DELAY = 14'd500;
    localparam logic [DELAY_W-1:0] RESET_MIN   = 14'd50;
    localparam logic [DELAY_W-1:0] RESET_MAX   = 14'd9000;
    localparam logic [STEP_W-1:0]  RESET_STEP  = 10'd100;
    localparam logic [DELAY_W-1:0] DELAY_MAX   = 14'h3FFF;

    typedef enum logic [OP_W-1:0] {
        OP_TICK   = 3'd0,
        OP_FASTER = 3'd1,
        OP_SLOWER = 3'd2,
        OP_START  = 3'd3,
        OP_STOP   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        REG_MIN_DELAY  = 2'd0,
        REG_MAX_DELAY  = 2'd1,
        REG_DELAY_STEP = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic [DELAY_W-1:0] min_delay;
        logic [DELAY_W-1:0] max_delay;
        logic [STEP_W-1:0]  delay_step;
    } cfg_t;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [PAT_W-1:0] pattern;
    } item_t;

    typedef struct packed {
        logic [LED_W-1:0] leds;
        logic             running;
    } result_t;

    function automatic logic [ADDR_W-1:0] pat_base(input logic [PAT_W-1:0] p);
        logic [ADDR_W-1:0] b;
        unique case (p)
            2'd0:    b = 6'd0;
            2'd1:    b = 6'd14;
            2'd2:    b = 6'd21;
            default: b = 6'd44;
        endcase
        return b;
    endfunction

    function automatic logic [IDX_W-1:0] pat_len(input logic [PAT_W-1:0] p);
        logic [IDX_W-1:0] l;
        unique case (p)
            2'd0:    l = 5'd14;
            2'd1:    l = 5'd7;
            2'd2:    l = 5'd23;
            default: l = 5'd12;
        endcase
        return l;
    endfunction

    function automatic logic [LED_W-1:0] rom_byte(input logic [ADDR_W-1:0] a);
        logic [LED_W-1:0] v;
        unique case (a)
            // chaser
            6'd0:  v = 8'h01;  6'd1:  v = 8'h02;  6'd2:  v = 8'h04;  6'd3:  v = 8'h08;
            6'd4:  v = 8'h10;  6'd5:  v = 8'h20;  6'd6:  v = 8'h40;  6'd7:  v = 8'h80;
            6'd8:  v = 8'h40;  6'd9:  v = 8'h20;  6'd10: v = 8'h10;  6'd11: v = 8'h08;
            6'd12: v = 8'h04;  6'd13: v = 8'h02;
            // crash
            6'd14: v = 8'h81;  6'd15: v = 8'h42;  6'd16: v = 8'h24;  6'd17: v = 8'h18;
            6'd18: v = 8'h18;  6'd19: v = 8'h24;  6'd20: v = 8'h42;
            // billiard
            6'd21: v = 8'h08;  6'd22: v = 8'h09;  6'd23: v = 8'h09;  6'd24: v = 8'h0B;
            6'd25: v = 8'h0B;  6'd26: v = 8'h09;  6'd27: v = 8'h09;  6'd28: v = 8'h08;
            6'd29: v = 8'h08;  6'd30: v = 8'h09;  6'd31: v = 8'h09;  6'd32: v = 8'h0B;
            6'd33: v = 8'h0B;  6'd34: v = 8'h09;  6'd35: v = 8'h08;  6'd36: v = 8'h09;
            6'd37: v = 8'h0B;  6'd38: v = 8'h0F;  6'd39: v = 8'h17;  6'd40: v = 8'h23;
            6'd41: v = 8'h41;  6'd42: v = 8'h80;  6'd43: v = 8'h00;
            // tennis
            6'd44: v = 8'h85;  6'd45: v = 8'h86;  6'd46: v = 8'h89;  6'd47: v = 8'h89;
            6'd48: v = 8'h91;  6'd49: v = 8'h91;  6'd50: v = 8'hA1;  6'd51: v = 8'h61;
            6'd52: v = 8'h91;  6'd53: v = 8'h91;  6'd54: v = 8'h89;  6'd55: v = 8'h89;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

@@ src/lps_if.sv @@
// lps_item_if and lps_result_if: valid/ready channels for input items and results
// depends on lps_pkg

interface lps_item_if;
    logic                     valid;
    logic                     ready;
    logic [lps_pkg::OP_W-1:0]  operation;
    logic [lps_pkg::PAT_W-1:0] pattern;

    modport source (output valid, operation, pattern, input ready);
    modport sink   (input valid, operation, pattern, output ready);
endinterface

interface lps_result_if;
    logic                     valid;
    logic                     ready;
    logic [lps_pkg::LED_W-1:0] leds;
    logic                     running;

    modport source (output valid, leds, running, input ready);
    modport sink   (input valid, leds, running, output ready);
endinterface

@@ src/lps_cfg_regs.sv @@
// lps_cfg_regs: delay limit and step registers behind the write port
// depends on lps_pkg

module lps_cfg_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [1:0]                cfg_index,
    input  logic [lps_pkg::CFG_W-1:0] cfg_data,
    output lps_pkg::cfg_t             cfg
);
    import lps_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_delay  <= RESET_MIN;
            cfg_reg.max_delay  <= RESET_MAX;
            cfg_reg.delay_step <= RESET_STEP;
        end
        else if (cfg_write_en)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_MIN_DELAY:  cfg_reg.min_delay  <= cfg_data[DELAY_W-1:0];
                REG_MAX_DELAY:  cfg_reg.max_delay  <= cfg_data[DELAY_W-1:0];
                REG_DELAY_STEP: cfg_reg.delay_step <= cfg_data[STEP_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/lps_in_stage.sv @@
// lps_in_stage: input register that holds one item until the update stage takes it
// depends on lps_pkg and lps_if

module lps_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    lps_item_if.sink       item,
    input  logic           advance,
    output logic           item_valid,
    output lps_pkg::item_t item_data
);
    import lps_pkg::*;

    logic  valid_reg;
    item_t data_reg;

    assign item.ready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            data_reg.operation <= item.operation;
            data_reg.pattern   <= item.pattern;
        end
    end

    assign item_valid = valid_reg;
    assign item_data  = data_reg;

endmodule

@@ src/lps_update.sv @@
// lps_update: sequencer state and the combinational update for one item
// depends on lps_pkg

module lps_update (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  lps_pkg::item_t   item_data,
    input  lps_pkg::cfg_t    cfg,
    output lps_pkg::result_t result_next
);
    import lps_pkg::*;

    logic [PAT_W-1:0]   active_pattern_reg, active_pattern_next;
    logic [IDX_W-1:0]   step_index_reg, step_index_next;
    logic [DELAY_W-1:0] countdown_reg, countdown_next;
    logic               playing_reg, playing_next;
    logic [DELAY_W-1:0] delay_reg [NUM_PAT];

    op_t                op;
    logic [PAT_W-1:0]   rd_pat;
    logic [DELAY_W-1:0] delay_rd;
    logic [DELAY_W-1:0] delay_next;
    logic               delay_we;
    logic [IDX_W-1:0]   step_inc;
    logic [DELAY_W-1:0] step_ext;
    logic [DELAY_W-1:0] dec;
    logic [DELAY_W:0]   sum_delay;
    logic [DELAY_W:0]   sum_count;
    logic [IDX_W-1:0]   step_shown;
    logic [ADDR_W-1:0]  rom_addr;

    assign op       = op_t'(item_data.operation);
    assign rd_pat   = (op == OP_START) ? item_data.pattern : active_pattern_reg;
    assign delay_rd = delay_reg[rd_pat];
    assign step_ext = {{(DELAY_W-STEP_W){1'b0}}, cfg.delay_step};

    always_comb
    begin
        active_pattern_next = active_pattern_reg;
        step_index_next     = step_index_reg;
        countdown_next      = countdown_reg;
        playing_next        = playing_reg;
        delay_next          = delay_rd;
        delay_we            = 1'b0;
        step_inc            = step_index_reg + 5'd1;
        dec                 = (delay_rd > step_ext) ? delay_rd - step_ext : '0;
        sum_delay           = {1'b0, delay_rd} + {1'b0, step_ext};
        sum_count           = {1'b0, countdown_reg} + {1'b0, step_ext};
        unique case (op)
            OP_TICK:
            begin
                if (playing_reg)
                begin
                    if (countdown_reg <= 14'd1)
                    begin
                        step_index_next = (step_inc >= pat_len(active_pattern_reg)) ?
                                          '0 : step_inc;
                        countdown_next  = delay_rd;
                    end
                    else
                    begin
                        countdown_next = countdown_reg - 14'd1;
                    end
                end
            end
            OP_FASTER:
            begin
                if (playing_reg && delay_rd > cfg.min_delay)
                begin
                    delay_we       = 1'b1;
                    delay_next     = (dec < cfg.min_delay) ? cfg.min_delay : dec;
                    countdown_next = ({1'b0, countdown_reg} > ({1'b0, step_ext} + 15'd1)) ?
                                     countdown_reg - step_ext : 14'd1;
                end
            end
            OP_SLOWER:
            begin
                if (playing_reg && delay_rd < cfg.max_delay)
                begin
                    delay_we       = 1'b1;
                    delay_next     = (sum_delay > {1'b0, cfg.max_delay}) ?
                                     cfg.max_delay : sum_delay[DELAY_W-1:0];
                    countdown_next = (sum_count > {1'b0, DELAY_MAX}) ?
                                     DELAY_MAX : sum_count[DELAY_W-1:0];
                end
            end
            OP_START:
            begin
                if ({1'b0, item_data.pattern} < PAT_LIMIT)
                begin
                    active_pattern_next = item_data.pattern;
                    step_index_next     = '0;
                    countdown_next      = delay_rd;
                    playing_next        = 1'b1;
                end
            end
            OP_STOP:
            begin
                playing_next = 1'b0;
            end
            default: ;
        endcase
    end

    assign step_shown = (step_index_next >= pat_len(active_pattern_next)) ?
                        '0 : step_index_next;
    assign rom_addr   = pat_base(active_pattern_next) + {1'b0, step_shown};

    assign result_next.leds    = playing_next ? rom_byte(rom_addr) : '0;
    assign result_next.running = playing_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_pattern_reg <= '0;
            step_index_reg     <= '0;
            countdown_reg      <= '0;
            playing_reg        <= 1'b0;
            for (int i = 0; i < NUM_PAT; i++)
            begin
                delay_reg[i] <= RESET_DELAY;
            end
        end
        else if (advance)
        begin
            active_pattern_reg <= active_pattern_next;
            step_index_reg     <= step_index_next;
            countdown_reg      <= countdown_next;
            playing_reg        <= playing_next;
            if (delay_we)
            begin
                delay_reg[active_pattern_reg] <= delay_next;
            end
        end
    end

endmodule

@@ src/lps_out_stage.sv @@
// lps_out_stage: result register that holds a result until the sink takes it
// depends on lps_pkg and lps_if

module lps_out_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  lps_pkg::result_t result_next,
    output logic             free,
    lps_result_if.source     result
);
    import lps_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    assign free = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result_next;
        end
    end

    assign result.valid   = valid_reg;
    assign result.leds    = data_reg.leds;
    assign result.running = data_reg.running;

endmodule

@@ src/led_pattern_sequencer_core.sv @@
// led_pattern_sequencer_core: top level of the eight-led pattern sequencer
// depends on lps_pkg, lps_if, lps_cfg_regs, lps_in_stage, lps_update, lps_out_stage
//
// Plays one of four led patterns (chaser, crash, billiard, tennis), each with its own
// step delay in ticks. Every item (tick, faster, slower, start, stop) yields exactly one
// result with the current led levels and the running flag. An item passes an input
// register, the update logic and a result register; one item is taken per clock while
// the result side does not stall. A result is presented once its item has left the input
// register and been loaded into the result register. The user must write delay limits
// and step size through the cfg port only while no item is in flight, which the block does not enforce.

module led_pattern_sequencer_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [1:0]                cfg_index,
    input  logic [lps_pkg::CFG_W-1:0] cfg_data,
    lps_item_if.sink                  item,
    lps_result_if.source              result
);
    import lps_pkg::*;

    cfg_t    cfg;
    item_t   item_data;
    result_t result_next;
    logic    item_valid;
    logic    out_free;
    logic    advance;

    assign advance = item_valid && out_free;

    lps_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    lps_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .advance    (advance),
        .item_valid (item_valid),
        .item_data  (item_data)
    );

    lps_update u_update (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .item_data   (item_data),
        .cfg         (cfg),
        .result_next (result_next)
    );

    lps_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .result_next (result_next),
        .free        (out_free),
        .result      (result)
    );

    // leds dark whenever the pattern is stopped
    a_dark_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.running) |-> (result.leds == '0))
        else $error("leds lit while stopped");

    // a stop item always produces a stopped result
    a_stop_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && op_t'(item_data.operation) == OP_STOP) |=>
        (result.valid && !result.running))
        else $error("stop did not halt the pattern");

    // input held off only while an item waits in the input register
    a_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (item_valid && !out_free))
        else $error("input stalled without a waiting item");

endmodule
